### rtl/swm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swm_pkg: shared types for the sliding window maximum
// Width of the window size register and the control word that drives the
// row of max cells.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int WIN_BITS = 7;

	typedef struct packed {
		logic accept;
		logic shift;
		logic shrink;
		logic clear;
	} swm_ctl_t;

endpackage
`default_nettype wire

### rtl/swm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swm_if: stream channels of the sliding window maximum
// Sample channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface swm_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          frame_end;

	modport source(output valid, output sample, output frame_end, input ready);
	modport sink(input valid, input sample, input frame_end, output ready);
endinterface

interface swm_out_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] window_max;
	logic                          is_final;

	modport source(output valid, output window_max, output is_final, input ready);
	modport sink(input valid, input window_max, input is_final, output ready);
endinterface
`default_nettype wire

### rtl/swm_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swm_cell: one cell of the max chain
// Holds the maximum over a run of recent samples ending at the newest one;
// cell j covers j fewer samples than cell 0. Takes its neighbor's run on a
// shift and folds in the new sample.
// ----------------------------------------------------------------------------
module swm_cell #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  swm_pkg::swm_ctl_t             ctl,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic signed [SAMPLE_BITS-1:0] nb_val,
	input  logic                          nb_vld,
	input  logic                          prv_vld,
	output logic signed [SAMPLE_BITS-1:0] val_q,
	output logic                          vld_q
);
	import swm_pkg::*;

	logic signed [SAMPLE_BITS-1:0] src;
	logic                          src_vld;
	logic signed [SAMPLE_BITS-1:0] val_d;

	always_comb begin
		src     = ctl.shift ? nb_val : val_q;
		src_vld = ctl.shift ? nb_vld : vld_q;
		val_d   = (src_vld && (src > sample)) ? src : sample;
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			val_q <= val_d;
		end else if (ctl.shrink) begin
			val_q <= nb_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.accept) begin
			if (ctl.clear) begin
				vld_q <= 1'b0;
			end else if (ctl.shift) begin
				vld_q <= vld_q;
			end else begin
				vld_q <= prv_vld;
			end
		end else if (ctl.shrink) begin
			vld_q <= nb_vld;
		end
	end

endmodule
`default_nettype wire

### rtl/swm_obuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swm_obuf: result queue
// Four-entry queue between the max chain and the result channel.
// ----------------------------------------------------------------------------
module swm_obuf #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic signed [SAMPLE_BITS-1:0] push_val,
	input  logic                          push_final,
	output logic [2:0]                    level_q,
	swm_out_if.source                     maxima
);
	import swm_pkg::*;

	localparam int DEPTH = 4;

	logic signed [SAMPLE_BITS-1:0] mem_val [DEPTH];
	logic                          mem_fin [DEPTH];
	logic [1:0]                    wr_ptr_q;
	logic [1:0]                    rd_ptr_q;
	logic                          pop;

	assign pop               = maxima.valid && maxima.ready;
	assign maxima.valid      = (level_q != 3'd0);
	assign maxima.window_max = mem_val[rd_ptr_q];
	assign maxima.is_final   = mem_fin[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_val[wr_ptr_q] <= push_val;
			mem_fin[wr_ptr_q] <= push_final;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			level_q  <= 3'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + 3'd1;
				2'b01:   level_q <= level_q - 3'd1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/sliding_window_maximum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_maximum: running maximum over a window of signed samples
// Samples arrive as beats on the stream channel; frame_end marks the last
// sample of a frame. Once window_size samples of the frame have arrived, each
// beat yields one beat on the maxima channel carrying the maximum of the
// samples still in the window. The last beat of a frame always yields a
// result with is_final set, then the frame state clears.
// window_size is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, which the block does not enforce. 0 acts as 1,
// values above MAX_WINDOW act as MAX_WINDOW. Each result passes through the
// emit_s1/final_s1 registers and the result queue before it shows on maxima.
// Throughput: one sample per cycle while stream.ready is high, set by the
// row of MAX_WINDOW compare cells that all update together on each beat.
// After a window_size write that shrinks the window below the samples held,
// stream.ready stays low while the cells drop one oldest run per excess sample.
// A four-beat result queue absorbs stalls on maxima; stream.ready drops once
// it cannot take another result.
// Reset clears the frame, empties the queue and sets window_size to 1.
// ----------------------------------------------------------------------------
module sliding_window_maximum #(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [swm_pkg::WIN_BITS-1:0] cfg_wdata,
	swm_in_if.sink                       stream,
	swm_out_if.source                    maxima
);
	import swm_pkg::*;

	localparam int LW = $clog2(MAX_WINDOW + 1);
	localparam int CW = (LW > WIN_BITS) ? LW : WIN_BITS;

	logic [WIN_BITS-1:0]           window_size_q;
	logic [LW-1:0]                 len_q;
	logic [LW-1:0]                 fill_q;
	logic                          emit_s1;
	logic                          final_s1;
	logic [2:0]                    obuf_level;

	logic [CW-1:0]                 ws_ext;
	logic [CW-1:0]                 win_c;
	logic [LW-1:0]                 win_eff;
	logic [LW-1:0]                 fill_inc;
	logic                          shrink;
	logic                          acc;
	logic                          emit;
	swm_ctl_t                      ctl;

	logic signed [SAMPLE_BITS-1:0] cell_val [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]         cell_vld;
	logic signed [SAMPLE_BITS-1:0] nb_val [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]         nb_vld;
	logic [MAX_WINDOW-1:0]         prv_vld;

	always_comb begin
		ws_ext = CW'(window_size_q);
		if (ws_ext == '0) begin
			win_c = CW'(1);
		end else if (ws_ext > CW'(MAX_WINDOW)) begin
			win_c = CW'(MAX_WINDOW);
		end else begin
			win_c = ws_ext;
		end
		win_eff  = LW'(win_c);
		fill_inc = (fill_q == LW'(MAX_WINDOW)) ? fill_q : fill_q + LW'(1);
		shrink   = (len_q > win_eff);
	end

	assign stream.ready = !shrink && (({1'b0, obuf_level} + {3'd0, emit_s1}) < 4'd4);
	assign acc          = stream.valid && stream.ready;
	assign emit         = acc && ((fill_inc >= win_eff) || stream.frame_end);

	always_comb begin
		ctl.accept = acc;
		ctl.shift  = (len_q == win_eff);
		ctl.shrink = shrink;
		ctl.clear  = stream.frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WIN_BITS'(1);
		end else if (cfg_we) begin
			window_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			fill_q   <= '0;
			emit_s1  <= 1'b0;
			final_s1 <= 1'b0;
		end else begin
			emit_s1  <= emit;
			final_s1 <= stream.frame_end;
			if (acc) begin
				if (stream.frame_end) begin
					len_q  <= '0;
					fill_q <= '0;
				end else begin
					len_q  <= ctl.shift ? len_q : len_q + LW'(1);
					fill_q <= fill_inc;
				end
			end else if (shrink) begin
				len_q <= len_q - LW'(1);
			end
		end
	end

	genvar j;
	for (j = 0; j < MAX_WINDOW; j++) begin : g_cell
		if (j == MAX_WINDOW - 1) begin : g_tail
			assign nb_val[j] = '0;
			assign nb_vld[j] = 1'b0;
		end else begin : g_body
			assign nb_val[j] = cell_val[j+1];
			assign nb_vld[j] = cell_vld[j+1];
		end
		if (j == 0) begin : g_head
			assign prv_vld[j] = 1'b1;
		end else begin : g_link
			assign prv_vld[j] = cell_vld[j-1];
		end

		swm_cell #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.sample (stream.sample),
			.nb_val (nb_val[j]),
			.nb_vld (nb_vld[j]),
			.prv_vld(prv_vld[j]),
			.val_q  (cell_val[j]),
			.vld_q  (cell_vld[j])
		);
	end

	swm_obuf #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit_s1),
		.push_val  (cell_val[0]),
		.push_final(final_s1),
		.level_q   (obuf_level),
		.maxima    (maxima)
	);

	a_len_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_vld) == int'(len_q))
		else $error("cell valid bits disagree with window length");

	a_len_fill: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= fill_q)
		else $error("window length exceeds frame fill");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(stream.valid && stream.ready && stream.frame_end) |=> (len_q == '0 && fill_q == '0))
		else $error("frame state not cleared after final beat");

	a_obuf_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit_s1 |-> (obuf_level < 3'd4 || maxima.ready))
		else $error("result pushed into a full queue");

endmodule
`default_nettype wire
